@@ design/hbb_pkg.sv @@
// ----------------------------------------------------------------------------
// hbb_pkg
// Shared constants, register codes and record types of the histogram bucket
// builder.
// ----------------------------------------------------------------------------
package hbb_pkg;

    localparam int unsigned HBB_MAX_VERTICES = 65536;

    localparam int HBB_ADDR_W    = 4;
    localparam int HBB_DATA_W    = 32;
    localparam int HBB_COUNT_W   = 32;
    localparam int HBB_SUM_W     = 48;
    localparam int HBB_ITEMS_W   = 17;
    localparam int HBB_IDX_OUT_W = 16;
    localparam int HBB_TDATA_O_W = 2 * HBB_IDX_OUT_W + HBB_SUM_W;

    localparam int HBB_FIFO_DEPTH = 4;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE         = 2'd0;
    localparam logic [1:0] REG_DEPTH_TARGET = 2'd1;
    localparam logic [1:0] REG_BUCKET_WIDTH = 2'd2;

    localparam logic MODE_EQUI_DEPTH = 1'b0;
    localparam logic MODE_EQUI_WIDTH = 1'b1;

    localparam logic [31:0]          RST_DEPTH_TARGET = 32'd100;
    localparam logic [HBB_ITEMS_W-1:0] RST_BUCKET_WIDTH = 17'd16;

    typedef struct packed {
        logic                    mode;
        logic [31:0]             depth_target;
        logic [HBB_ITEMS_W-1:0]  bucket_width;
    } hbb_cfg_t;

    typedef struct packed {
        logic [HBB_IDX_OUT_W-1:0] bucket_start;
        logic [HBB_IDX_OUT_W-1:0] bucket_end;
        logic [HBB_SUM_W-1:0]     bucket_sum;
        logic                     relation_done;
        logic                     run_last;
    } hbb_result_t;

endpackage

@@ design/hbb_regs.sv @@
// ----------------------------------------------------------------------------
// hbb_regs
// APB configuration registers: mode, depth target and bucket width.
// ----------------------------------------------------------------------------
module hbb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbb_pkg::HBB_ADDR_W-1:0] paddr,
    input  logic [hbb_pkg::HBB_DATA_W-1:0] pwdata,
    output logic [hbb_pkg::HBB_DATA_W-1:0] prdata,
    output logic                          pready,
    output hbb_pkg::hbb_cfg_t             cfg
);
    import hbb_pkg::*;

    logic                   mode_reg;
    logic [31:0]            depth_target_reg;
    logic [HBB_ITEMS_W-1:0] bucket_width_reg;
    logic [1:0]             reg_index;
    logic                   wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_EQUI_DEPTH;
            depth_target_reg <= RST_DEPTH_TARGET;
            bucket_width_reg <= RST_BUCKET_WIDTH;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_MODE:         mode_reg         <= pwdata[0];
                REG_DEPTH_TARGET: depth_target_reg <= pwdata;
                REG_BUCKET_WIDTH: bucket_width_reg <= pwdata[HBB_ITEMS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_MODE:         prdata = {31'd0, mode_reg};
            REG_DEPTH_TARGET: prdata = depth_target_reg;
            REG_BUCKET_WIDTH: prdata = {{(HBB_DATA_W-HBB_ITEMS_W){1'b0}}, bucket_width_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.mode         = mode_reg;
    assign cfg.depth_target = depth_target_reg;
    assign cfg.bucket_width = bucket_width_reg;

endmodule

@@ design/hbb_core.sv @@
// ----------------------------------------------------------------------------
// hbb_core
// Input register and open-bucket state; closes buckets and hands zero, one
// or two results to the output buffer per item.
// ----------------------------------------------------------------------------
module hbb_core #(
    parameter int unsigned MAX_VERTICES = hbb_pkg::HBB_MAX_VERTICES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hbb_pkg::hbb_cfg_t                cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hbb_pkg::HBB_COUNT_W-1:0]  s_count,
    input  logic                             s_last,
    input  logic                             room,
    output logic [1:0]                       push_n,
    output hbb_pkg::hbb_result_t             res0,
    output hbb_pkg::hbb_result_t             res1
);
    import hbb_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_VERTICES - 1);
    localparam logic [HBB_ITEMS_W-1:0] ITEMS_MAX = '1;
    localparam logic [HBB_SUM_W-1:0]   SUM_MAX   = '1;

    logic                   in_valid_reg;
    logic [HBB_COUNT_W-1:0] in_value_reg;
    logic                   in_last_reg;

    logic [IDX_W-1:0]       open_start_reg, open_start_next;
    logic [IDX_W-1:0]       next_index_reg, next_index_next;
    logic [HBB_SUM_W-1:0]   open_sum_reg,   open_sum_next;
    logic [HBB_ITEMS_W-1:0] open_items_reg, open_items_next;

    logic                   proc;
    logic [IDX_W-1:0]       idx, start_eff, idx_adv, idx_prev;
    logic [HBB_SUM_W:0]     sum_wide;
    logic [HBB_SUM_W-1:0]   sum_sat;
    logic [HBB_ITEMS_W-1:0] items_inc, width_eff;
    logic                   split, closes;

    assign proc    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            in_value_reg <= s_count;
            in_last_reg  <= s_last;
        end
    end

    always_comb
    begin
        idx       = next_index_reg;
        start_eff = (open_items_reg == '0) ? idx : open_start_reg;
        idx_adv   = (idx == IDX_TOP) ? '0 : idx + IDX_W'(1);
        idx_prev  = (idx == '0) ? IDX_TOP : idx - IDX_W'(1);

        // saturating running sum and item count
        sum_wide  = {1'b0, open_sum_reg} + (HBB_SUM_W+1)'(in_value_reg);
        sum_sat   = sum_wide[HBB_SUM_W] ? SUM_MAX : sum_wide[HBB_SUM_W-1:0];
        items_inc = (open_items_reg == ITEMS_MAX) ? open_items_reg
                                                  : open_items_reg + HBB_ITEMS_W'(1);
        width_eff = (cfg.bucket_width == '0) ? HBB_ITEMS_W'(1) : cfg.bucket_width;

        split = (cfg.mode == MODE_EQUI_DEPTH) && (open_sum_reg != '0)
             && (in_value_reg > cfg.depth_target);
        if (cfg.mode == MODE_EQUI_DEPTH)
        begin
            closes = split || (sum_sat >= HBB_SUM_W'(cfg.depth_target)) || in_last_reg;
        end
        else
        begin
            closes = (items_inc >= width_eff) || in_last_reg;
        end

        res0.bucket_start = HBB_IDX_OUT_W'(start_eff);
        res1.bucket_start = HBB_IDX_OUT_W'(idx);
        res1.bucket_end   = HBB_IDX_OUT_W'(idx);
        res1.bucket_sum   = HBB_SUM_W'(in_value_reg);
        res1.relation_done = in_last_reg;
        res1.run_last     = 1'b1;
        if (split)
        begin
            // open bucket closes at the previous index, count stands alone
            res0.bucket_end    = HBB_IDX_OUT_W'(idx_prev);
            res0.bucket_sum    = open_sum_reg;
            res0.relation_done = 1'b0;
            res0.run_last      = 1'b0;
        end
        else
        begin
            res0.bucket_end    = HBB_IDX_OUT_W'(idx);
            res0.bucket_sum    = sum_sat;
            res0.relation_done = in_last_reg;
            res0.run_last      = 1'b1;
        end

        if (!proc)
        begin
            push_n = 2'd0;
        end
        else if (split)
        begin
            push_n = 2'd2;
        end
        else
        begin
            push_n = closes ? 2'd1 : 2'd0;
        end

        next_index_next = in_last_reg ? '0 : idx_adv;
        if (closes)
        begin
            open_sum_next   = '0;
            open_items_next = '0;
            open_start_next = next_index_next;
        end
        else
        begin
            open_sum_next   = sum_sat;
            open_items_next = items_inc;
            open_start_next = start_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_start_reg <= '0;
            next_index_reg <= '0;
            open_sum_reg   <= '0;
            open_items_reg <= '0;
        end
        else if (proc)
        begin
            open_start_reg <= open_start_next;
            next_index_reg <= next_index_next;
            open_sum_reg   <= open_sum_next;
            open_items_reg <= open_items_next;
        end
    end

    // an empty bucket never carries a sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (open_items_reg == '0) |-> (open_sum_reg == '0))
        else $error("empty bucket holds a nonzero sum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> (next_index_reg == '0 && open_items_reg == '0))
        else $error("relation end did not restart indexing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (cfg.mode == MODE_EQUI_DEPTH && open_items_reg != '0))
        else $error("two buckets from one item outside equi-depth split");

endmodule

@@ design/hbb_out_fifo.sv @@
// ----------------------------------------------------------------------------
// hbb_out_fifo
// Small result buffer: takes up to two results per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module hbb_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_n,
    input  hbb_pkg::hbb_result_t res0,
    input  hbb_pkg::hbb_result_t res1,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hbb_pkg::hbb_result_t out_res
);
    import hbb_pkg::*;

    localparam int PTR_W = $clog2(HBB_FIFO_DEPTH);
    localparam int CNT_W = $clog2(HBB_FIFO_DEPTH + 1);

    hbb_result_t      entry_reg [HBB_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a split item of two results
    assign room      = (count_reg <= CNT_W'(HBB_FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (CNT_W'(push_n) + count_reg <= CNT_W'(HBB_FIFO_DEPTH)))
        else $error("result buffer overflow");

endmodule

@@ design/histogram_bucket_builder.sv @@
// ----------------------------------------------------------------------------
// histogram_bucket_builder
// Equi-depth / equi-width histogram bucketing over a stream of frequency
// counts.
// ----------------------------------------------------------------------------
// Counts enter one per cycle while s_tready is high, in vertex index order,
// the last count of a relation flagged by s_tlast. Each count passes an input
// register, then one add-and-compare on the open bucket's running sum updates
// the bucket state and writes closed buckets into a four-entry result buffer.
// A new count is taken every cycle while the buffer has room for two results;
// results leave one per cycle while m_tready is high, and an item that splits
// a bucket in equi-depth mode gives two results. m_tlast marks the last
// result of an item, m_tuser the relation's final bucket. Registers: mode at
// 0x0, depth_target at 0x4, bucket_width at 0x8; change them only while idle.
module histogram_bucket_builder #(
    parameter int unsigned MAX_VERTICES = hbb_pkg::HBB_MAX_VERTICES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hbb_pkg::HBB_ADDR_W-1:0]     paddr,
    input  logic [hbb_pkg::HBB_DATA_W-1:0]     pwdata,
    output logic [hbb_pkg::HBB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hbb_pkg::HBB_COUNT_W-1:0]    s_tdata,  // count_value
    input  logic                               s_tlast,  // relation_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hbb_pkg::HBB_TDATA_O_W-1:0]  m_tdata,  // bucket_start, bucket_end, bucket_sum
    output logic                               m_tuser,  // relation_done
    output logic                               m_tlast   // run_last
);
    import hbb_pkg::*;

    hbb_cfg_t    cfg;
    hbb_result_t res0, res1, out_res;
    logic [1:0]  push_n;
    logic        room;

    hbb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbb_core #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_count (s_tdata),
        .s_last  (s_tlast),
        .room    (room),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1)
    );

    hbb_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.bucket_sum, out_res.bucket_end, out_res.bucket_start};
    assign m_tuser = out_res.relation_done;
    assign m_tlast = out_res.run_last;

endmodule

@@ tb/histogram_bucket_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_bucket_builder_tb
// Self-checking testbench for the histogram bucket builder: streams frequency
// counts through the block under both bucketing modes and many register
// settings. It predicts every closed bucket and checks each one, field by
// field, as it leaves the block.
// ----------------------------------------------------------------------------
module histogram_bucket_builder_tb;
    import hbb_pkg::*;

    localparam int CYCLE_LIMIT        = 2_000_000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int RANDOM_CHUNK_ITEMS = 93;
    localparam int LARGE_SUM_ITEMS    = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [HBB_ADDR_W-1:0]    paddr = '0;
    logic [HBB_DATA_W-1:0]    pwdata = '0;
    logic [HBB_DATA_W-1:0]    prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [HBB_COUNT_W-1:0]   s_tdata = '0;    // count_value
    logic        s_tlast = 1'b0;               // relation_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [HBB_TDATA_O_W-1:0] m_tdata;         // bucket_start, bucket_end, bucket_sum
    logic        m_tuser;                      // relation_done
    logic        m_tlast;                      // run_last

    // predictor state and register copy
    logic                   cfg_mode;
    logic [31:0]            cfg_target;
    logic [HBB_ITEMS_W-1:0] cfg_width;
    logic [15:0]            open_start;
    logic [15:0]            next_idx;
    logic [HBB_SUM_W-1:0]   open_sum;
    logic [HBB_ITEMS_W-1:0] open_items;

    hbb_result_t bucket_q[$];

    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_cycles = 0;
    int cycle_cnt = 0;
    int mismatches = 0;
    int counts_sent = 0;
    int relations_sent = 0;
    int buckets_checked = 0;
    int reg_writes = 0;

    histogram_bucket_builder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d buckets outstanding",
                     cycle_cnt, bucket_q.size());
            $display("histogram_bucket_builder_tb: FAIL");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (sink_hold_cycles > 0)
        begin
            sink_hold_cycles = sink_hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        $display("mismatch on bucket %0d: %s expected 0x%0h got 0x%0h",
                 buckets_checked, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        hbb_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bucket_q.size() == 0)
                report_mismatch("unexpected bucket, start", '0, 48'(m_tdata[15:0]));
            else
            begin
                want = bucket_q.pop_front();
                if (m_tdata[15:0] !== want.bucket_start)
                    report_mismatch("bucket_start", 48'(want.bucket_start),
                                    48'(m_tdata[15:0]));
                if (m_tdata[31:16] !== want.bucket_end)
                    report_mismatch("bucket_end", 48'(want.bucket_end),
                                    48'(m_tdata[31:16]));
                if (m_tdata[79:32] !== want.bucket_sum)
                    report_mismatch("bucket_sum", want.bucket_sum, m_tdata[79:32]);
                if (m_tuser !== want.relation_done)
                    report_mismatch("relation_done", 48'(want.relation_done), 48'(m_tuser));
                if (m_tlast !== want.run_last)
                    report_mismatch("run_last", 48'(want.run_last), 48'(m_tlast));
            end
            buckets_checked++;
        end
    end

    function automatic void add_to_bucket(input logic [31:0] v);
        logic [HBB_SUM_W:0] s;
        s = {1'b0, open_sum} + {17'd0, v};
        open_sum = s[HBB_SUM_W] ? {HBB_SUM_W{1'b1}} : s[HBB_SUM_W-1:0];
        if (open_items != {HBB_ITEMS_W{1'b1}})
            open_items = open_items + HBB_ITEMS_W'(1);
    endfunction

    // works out the buckets closed by one count and queues them
    function automatic void predict_buckets(input logic [31:0] v, input logic last);
        hbb_result_t res[2];
        int n;
        logic [15:0] idx;
        logic [HBB_ITEMS_W-1:0] w;
        logic closed;
        n = 0;
        idx = next_idx;
        closed = 1'b0;
        if (open_items == 0)
            open_start = idx;
        if (cfg_mode == MODE_EQUI_DEPTH)
        begin
            if (open_sum != 0 && v > cfg_target)
            begin
                // open bucket ends one index back, the big count stands alone
                res[0] = '{open_start, idx - 16'd1, open_sum, 1'b0, 1'b0};
                res[1] = '{idx, idx, {16'd0, v}, last, 1'b0};
                n = 2;
                closed = 1'b1;
            end
            else
            begin
                add_to_bucket(v);
                if (open_sum >= {16'd0, cfg_target} || last)
                begin
                    res[0] = '{open_start, idx, open_sum, last, 1'b0};
                    n = 1;
                    closed = 1'b1;
                end
            end
        end
        else
        begin
            w = (cfg_width == 0) ? HBB_ITEMS_W'(1) : cfg_width;
            add_to_bucket(v);
            if (open_items >= w || last)
            begin
                res[0] = '{open_start, idx, open_sum, last, 1'b0};
                n = 1;
                closed = 1'b1;
            end
        end
        next_idx = last ? 16'd0 : idx + 16'd1;
        if (closed)
        begin
            open_sum = '0;
            open_items = '0;
            open_start = next_idx;
        end
        if (n > 0)
            res[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            bucket_q.insert(bucket_q.size(), res[i]);
    endfunction

    // offers one count; called right after the previous accept or an idle point
    task automatic send_count(input logic [31:0] v, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_buckets(v, last);
        counts_sent++;
        if (last)
            relations_sent++;
    endtask

    // stop sending, let every predicted bucket arrive, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (bucket_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_idx)
            REG_MODE:         cfg_mode = value[0];
            REG_DEPTH_TARGET: cfg_target = value;
            REG_BUCKET_WIDTH: cfg_width = value[HBB_ITEMS_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic m, input logic [31:0] target,
                              input logic [HBB_ITEMS_W-1:0] width);
        wait_idle();
        apb_write(REG_MODE, {31'd0, m});
        apb_write(REG_DEPTH_TARGET, target);
        apb_write(REG_BUCKET_WIDTH, {{(32-HBB_ITEMS_W){1'b0}}, width});
    endtask

    function automatic logic [31:0] pick_count();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return 32'd0;
        if (sel < 25)
            return 32'hFFFF_FFFF;
        if (sel < 45)
            return $urandom;
        if (sel < 55)
            return cfg_target;
        if (sel < 70 && cfg_target != 32'hFFFF_FFFF)
            return $urandom_range(32'hFFFF_FFFF, cfg_target + 1);
        return $urandom_range(cfg_target / 3 + 1, 0);
    endfunction

    task automatic random_config();
        logic m;
        logic [31:0] target;
        logic [HBB_ITEMS_W-1:0] width;
        m = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: target = 32'd0;
            1: target = 32'd1;
            2: target = $urandom_range(300, 2);
            3: target = $urandom;
            4: target = 32'hFFFF_FFFF;
            default: target = RST_DEPTH_TARGET;
        endcase
        case ($urandom_range(6))
            0: width = '0;
            1: width = 17'd1;
            2: width = HBB_ITEMS_W'($urandom_range(24, 2));
            3: width = 17'd65536;
            4: width = 17'h1FFFF;
            5: width = HBB_ITEMS_W'($urandom_range(17'h1FFFF, 0));
            default: width = RST_BUCKET_WIDTH;
        endcase
        set_config(m, target, width);
    endtask

    task automatic test_depth_basics();
        set_config(MODE_EQUI_DEPTH, RST_DEPTH_TARGET, RST_BUCKET_WIDTH);
        send_count(32'd40, 1'b0);
        send_count(32'd60, 1'b0);         // reaches target exactly
        send_count(32'd0, 1'b0);
        send_count(32'd30, 1'b0);
        send_count(32'd500, 1'b0);        // splits the open bucket
        send_count(32'd150, 1'b0);        // over target into an empty bucket
        send_count(32'hFFFF_FFFF, 1'b1);
        send_count(32'd10, 1'b0);
        send_count(32'd200, 1'b1);        // split on the relation's last count
        send_count(32'd5, 1'b1);          // one-count relation
    endtask

    task automatic test_zero_target();
        set_config(MODE_EQUI_DEPTH, 32'd0, RST_BUCKET_WIDTH);
        send_count(32'd0, 1'b0);
        send_count(32'd7, 1'b0);
        send_count(32'd0, 1'b1);
    endtask

    task automatic test_equi_width();
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd3);
        for (int i = 1; i <= 5; i++)
            send_count(i, i == 5);
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd0);
        send_count(32'd9, 1'b0);
        send_count(32'd8, 1'b1);
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd65536);
        send_count(32'hFFFF_FFFF, 1'b0);
        send_count(32'hFFFF_FFFF, 1'b1);
    endtask

    // settings change while a bucket is open
    task automatic test_config_midbucket();
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd4);
        repeat (3) send_count(32'd1, 1'b0);
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd2);
        send_count(32'd1, 1'b0);          // width already passed
        send_count(32'd1, 1'b0);
        send_count(32'd1, 1'b0);
        send_count(32'd1, 1'b0);
        set_config(MODE_EQUI_DEPTH, 32'd3, 17'd2);
        send_count(32'd1, 1'b0);
        send_count(32'd1, 1'b1);
    endtask

    // output held off while counts keep coming, so the input stalls
    task automatic test_backpressure();
        set_config(MODE_EQUI_DEPTH, 32'd1, RST_BUCKET_WIDTH);
        sink_hold_cycles = 300;
        for (int i = 0; i < 80; i++)
            send_count((i % 3 == 0) ? 32'd0 : 32'd5, i == 79);
        wait_idle();
    endtask

    // one wide bucket of full-scale counts, closed by the relation end
    task automatic test_large_sums();
        set_config(MODE_EQUI_WIDTH, RST_DEPTH_TARGET, 17'd70000);
        for (int i = 0; i < LARGE_SUM_ITEMS; i++)
            send_count(32'hFFFF_FFFF, i == LARGE_SUM_ITEMS - 1);
    endtask

    task automatic test_random();
        int left;
        int len;
        int sel;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    sink_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 13;
                    sink_stall_pct = 13;
                end
            endcase
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                random_config();
                left = RANDOM_CHUNK_ITEMS;
                // relations may be cut off by the next settings change
                while (left > 0)
                begin
                    sel = $urandom_range(99);
                    if (sel < 10)
                        len = 1;
                    else if (sel < 75)
                        len = $urandom_range(20, 2);
                    else
                        len = $urandom_range(120, 21);
                    for (int i = 0; i < len && left > 0; i++)
                    begin
                        send_count(pick_count(), i == len - 1);
                        left--;
                    end
                end
            end
        end
        send_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        cfg_mode = MODE_EQUI_DEPTH;
        cfg_target = RST_DEPTH_TARGET;
        cfg_width = RST_BUCKET_WIDTH;
        open_start = '0;
        next_idx = '0;
        open_sum = '0;
        open_items = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_depth_basics();
        test_zero_target();
        test_equi_width();
        test_config_midbucket();
        test_backpressure();
        test_large_sums();
        test_random();
        wait_idle();

        if (bucket_q.size() != 0)
            report_mismatch("buckets never seen", 48'(bucket_q.size()), '0);
        $display("sent %0d counts in %0d relations, checked %0d buckets, %0d register writes",
                 counts_sent, relations_sent, buckets_checked, reg_writes);
        $display("both modes, zero target and width, settings changed mid-bucket, wide sums");
        $display("random settings under sender idling, output stalls and a long hold-off");
        if (mismatches == 0)
            $display("histogram_bucket_builder_tb: PASS");
        else
            $display("histogram_bucket_builder_tb: FAIL");
        $finish;
    end

endmodule

@@ histogram_bucket_builder.f @@
design/hbb_pkg.sv
design/hbb_regs.sv
design/hbb_core.sv
design/hbb_out_fifo.sv
design/histogram_bucket_builder.sv
tb/histogram_bucket_builder_tb.sv
